// ===== hdl/rcl_pkg.sv =====
// Shared constants, codes and control structs of the row cache LFU manager.
`timescale 1ns / 1ps

package rcl_pkg;

    // Row space and field widths.
    localparam int NUM_ROWS     = 1024;
    localparam int ROW_W        = 10;
    localparam int CAP_W        = 11;
    localparam int MISS_W       = 32;
    localparam int USE_BITS_DEF = 16;

    // Capacity register reset value and the smallest capacity honored.
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [CAP_W-1:0] CAP_MIN   = 11'd2;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT,
        S_PLACE
    } t_state;

    // Access request to the row entry memory (data travels beside it).
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } t_mem_ctl;

    // Control of the victim scan.
    typedef struct packed {
        logic             start;
        logic             sample;
        logic [ROW_W-1:0] idx;
    } t_scan_ctl;

    // Outcome of the victim scan.
    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] victim;
        logic [ROW_W-1:0] vbuf;
    } t_scan_res;

endpackage

// ===== hdl/rcl_if.sv =====
// Valid/ready channel interfaces for row requests and their results.
`timescale 1ns / 1ps

interface rcl_req_if;
    logic                     valid;
    logic                     ready;
    logic [rcl_pkg::ROW_W-1:0] req_row;

    modport source (output valid, output req_row, input ready);
    modport sink   (input valid, input req_row, output ready);
endinterface

interface rcl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 outcome;
    logic [rcl_pkg::ROW_W-1:0]  buffer_slot;
    logic                       evicted_flag;
    logic [rcl_pkg::ROW_W-1:0]  evicted_row;
    logic [rcl_pkg::MISS_W-1:0] miss_total;

    modport source (output valid, output outcome, output buffer_slot,
                    output evicted_flag, output evicted_row, output miss_total,
                    input ready);
    modport sink   (input valid, input outcome, input buffer_slot,
                    input evicted_flag, input evicted_row, input miss_total,
                    output ready);
endinterface

// ===== hdl/rcl_entry_ram.sv =====
// Row entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module rcl_entry_ram #(
    parameter int DATA_W = 1 + rcl_pkg::USE_BITS_DEF + rcl_pkg::ROW_W
) (
    input  logic              i_clk,
    input  rcl_pkg::t_mem_ctl i_ctl,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [rcl_pkg::NUM_ROWS];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rcl_min_scan.sv =====
// Victim search: tracks the valid row with the fewest uses over a row sweep.
`timescale 1ns / 1ps

module rcl_min_scan #(
    parameter int USE_BITS = rcl_pkg::USE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rcl_pkg::t_scan_ctl        i_ctl,
    input  logic                      i_ent_valid,
    input  logic [USE_BITS-1:0]       i_ent_cnt,
    input  logic [rcl_pkg::ROW_W-1:0] i_ent_buf,
    output rcl_pkg::t_scan_res        o_res
);

    logic                      r_found;
    logic [USE_BITS-1:0]       r_best;
    logic [rcl_pkg::ROW_W-1:0] r_victim;
    logic [rcl_pkg::ROW_W-1:0] r_vbuf;
    logic                      take;

    // A strictly smaller count wins, so the lowest row keeps ties.
    assign take = i_ctl.sample && i_ent_valid && (!r_found || (i_ent_cnt < r_best));

    // Found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Best candidate so far.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best   <= i_ent_cnt;
            r_victim <= i_ctl.idx;
            r_vbuf   <= i_ent_buf;
        end
    end

    assign o_res.found  = r_found;
    assign o_res.victim = r_victim;
    assign o_res.vbuf   = r_vbuf;

`ifndef ASSERT_OFF
    // A sweep always begins with an empty candidate.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> !r_found)
        else $error("scan start did not clear the candidate");

    // Start and sampling never coincide.
    a_start_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.start && i_ctl.sample))
        else $error("scan start during sampling");

    // Once a candidate exists it stays until the next start.
    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_ctl.start) |=> r_found)
        else $error("scan candidate lost");
`endif

endmodule

// ===== hdl/row_cache_lfu_manager.sv =====
// Hit or fresh fill: S_LOOK checks the entry and loads the result into the output
// register once it is free. Eviction: S_SCAN sweeps all rows, one row entry per cycle through the
// single read port; S_EVICT frees the least used row and S_PLACE loads the result.
// One item is in flight at a time; a result may wait in the output register.
// Reset is synchronous, active low; it starts a clearing pass over all NUM_ROWS rows
// during which no item is accepted; configuration is always taken.
`timescale 1ns / 1ps

module row_cache_lfu_manager #(
    parameter int USE_BITS = rcl_pkg::USE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rcl_req_if.sink                   i_req,
    rcl_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [rcl_pkg::CAP_W-1:0] i_cfg_wdata
);

    localparam int ROW_W = rcl_pkg::ROW_W;
    localparam int CAP_W = rcl_pkg::CAP_W;
    localparam int MISS_W = rcl_pkg::MISS_W;
    localparam int ENT_W = 1 + USE_BITS + ROW_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(rcl_pkg::NUM_ROWS - 1);

    // State and registers.
    rcl_pkg::t_state   r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CAP_W-1:0]  r_held, n_held;
    logic [MISS_W-1:0] r_miss, n_miss;
    logic [ROW_W-1:0]  r_idx, n_idx;

    logic              r_out_valid;
    rcl_pkg::t_outcome r_outcome, n_outcome;
    logic [ROW_W-1:0]  r_slot, n_slot;
    logic              r_evf, n_evf;
    logic [ROW_W-1:0]  r_evrow, n_evrow;
    logic [MISS_W-1:0] r_misstot, n_misstot;
    logic              load_out;

    // Memory and scan connections.
    rcl_pkg::t_mem_ctl  mem_ctl;
    logic [ENT_W-1:0]   mem_wdata;
    logic [ENT_W-1:0]   mem_rdata;
    rcl_pkg::t_scan_ctl scan_ctl;
    rcl_pkg::t_scan_res scan_res;

    logic                ent_valid;
    logic [USE_BITS-1:0] ent_cnt;
    logic [ROW_W-1:0]    ent_buf;
    logic [CAP_W-1:0]    cap_eff;
    logic                out_free;
    logic                fresh_go;

    assign ent_valid = mem_rdata[ENT_W-1];
    assign ent_cnt   = mem_rdata[ROW_W +: USE_BITS];
    assign ent_buf   = mem_rdata[ROW_W-1:0];
    assign cap_eff   = (r_cap < rcl_pkg::CAP_MIN) ? rcl_pkg::CAP_MIN : r_cap;
    assign out_free  = !r_out_valid || o_rsp.ready;

    rcl_entry_ram #(
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    rcl_min_scan #(
        .USE_BITS (USE_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_ent_valid (ent_valid),
        .i_ent_cnt   (ent_cnt),
        .i_ent_buf   (ent_buf),
        .o_res       (scan_res)
    );

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rcl_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Sequencer and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcl_pkg::S_CLEAR;
            r_held  <= '0;
            r_miss  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_miss  <= n_miss;
            r_idx   <= n_idx;
        end
    end

    // Request row; payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_outcome <= n_outcome;
            r_slot    <= n_slot;
            r_evf     <= n_evf;
            r_evrow   <= n_evrow;
            r_misstot <= n_misstot;
        end
    end

    // Next state, memory accesses and results.
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_held    = r_held;
        n_miss    = r_miss;
        n_idx     = r_idx;
        mem_ctl   = '0;
        mem_wdata = '0;
        scan_ctl  = '0;
        load_out  = 1'b0;
        fresh_go  = 1'b0;
        n_outcome = rcl_pkg::OUT_HIT;
        n_slot    = '0;
        n_evf     = 1'b0;
        n_evrow   = '0;
        n_misstot = r_miss;

        case (r_state)
            rcl_pkg::S_CLEAR: begin
                // Clearing pass: every row invalid with a zero use count.
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = r_idx;
                n_idx         = r_idx + ROW_W'(1);
                if (r_idx == LAST_ROW) begin
                    n_state = rcl_pkg::S_IDLE;
                end
            end
            rcl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    mem_ctl.re    = 1'b1;
                    mem_ctl.raddr = i_req.req_row;
                    n_row         = i_req.req_row;
                    n_state       = rcl_pkg::S_LOOK;
                end
            end
            rcl_pkg::S_LOOK: begin
                if (ent_valid) begin
                    // Hit: bump the saturating use count.
                    if (out_free) begin
                        mem_ctl.we    = 1'b1;
                        mem_ctl.waddr = r_row;
                        mem_wdata     = {1'b1, (&ent_cnt) ? ent_cnt : ent_cnt + USE_BITS'(1),
                                         ent_buf};
                        load_out      = 1'b1;
                        n_outcome     = rcl_pkg::OUT_HIT;
                        n_slot        = ent_buf;
                        n_state       = rcl_pkg::S_IDLE;
                    end
                end else if (r_held >= cap_eff) begin
                    // Full: sweep all rows for the least used one.
                    mem_ctl.re     = 1'b1;
                    mem_ctl.raddr  = '0;
                    scan_ctl.start = 1'b1;
                    n_idx          = '0;
                    n_state        = rcl_pkg::S_SCAN;
                end else begin
                    fresh_go = out_free;
                end
            end
            rcl_pkg::S_SCAN: begin
                scan_ctl.sample = 1'b1;
                scan_ctl.idx    = r_idx;
                if (r_idx == LAST_ROW) begin
                    n_state = rcl_pkg::S_EVICT;
                end else begin
                    mem_ctl.re    = 1'b1;
                    mem_ctl.raddr = r_idx + ROW_W'(1);
                    n_idx         = r_idx + ROW_W'(1);
                end
            end
            rcl_pkg::S_EVICT: begin
                if (scan_res.found) begin
                    // Release the victim row.
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = scan_res.victim;
                    n_state       = rcl_pkg::S_PLACE;
                end else begin
                    fresh_go = out_free;
                end
            end
            rcl_pkg::S_PLACE: begin
                // Hand the victim's buffer to the requested row.
                if (out_free) begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = r_row;
                    mem_wdata     = {1'b1, USE_BITS'(1), scan_res.vbuf};
                    n_miss        = (&r_miss) ? r_miss : r_miss + MISS_W'(1);
                    load_out      = 1'b1;
                    n_outcome     = rcl_pkg::OUT_EVICT;
                    n_slot        = scan_res.vbuf;
                    n_evf         = 1'b1;
                    n_evrow       = scan_res.victim;
                    n_misstot     = n_miss;
                    n_state       = rcl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcl_pkg::S_IDLE;
            end
        endcase

        // Fill into the next fresh buffer.
        if (fresh_go) begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = r_row;
            mem_wdata     = {1'b1, USE_BITS'(1), r_held[ROW_W-1:0]};
            n_held        = r_held + CAP_W'(1);
            load_out      = 1'b1;
            n_outcome     = rcl_pkg::OUT_FILL;
            n_slot        = r_held[ROW_W-1:0];
            n_state       = rcl_pkg::S_IDLE;
        end
    end

    // Ports.
    assign i_req.ready        = (r_state == rcl_pkg::S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.outcome      = r_outcome;
    assign o_rsp.buffer_slot  = r_slot;
    assign o_rsp.evicted_flag = r_evf;
    assign o_rsp.evicted_row  = r_evrow;
    assign o_rsp.miss_total   = r_misstot;

`ifndef ASSERT_OFF
    // No more buffers are handed out than there are rows.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CAP_W'(rcl_pkg::NUM_ROWS))
        else $error("held buffer count exceeds row count");

    // The eviction flag matches the outcome code.
    a_evict_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_outcome == rcl_pkg::OUT_EVICT) == r_evf))
        else $error("eviction flag disagrees with outcome");

    // Without an eviction the evicted row reads zero.
    a_evrow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_evf) |-> (r_evrow == '0))
        else $error("evicted row set without eviction");

    // An accepted item is looked up in the next cycle.
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == rcl_pkg::S_LOOK))
        else $error("accepted item not looked up");

    // A result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_rsp.ready))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/rcl_lfu_checker.sv =====
// Checker that predicts and compares the results of the row cache LFU manager.
`timescale 1ns / 1ps

module rcl_lfu_checker #(
    parameter int USE_BITS = rcl_pkg::USE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rcl_req_if                        i_req,
    rcl_rsp_if                        i_rsp,
    input  logic                      i_cfg_we,
    input  logic [rcl_pkg::CAP_W-1:0] i_cfg_wdata,
    output int                        o_err_count,
    output int                        o_pending
);

    localparam int NUM_ROWS = rcl_pkg::NUM_ROWS;
    localparam int ROW_W    = rcl_pkg::ROW_W;
    localparam int CAP_W    = rcl_pkg::CAP_W;
    localparam int MISS_W   = rcl_pkg::MISS_W;

    // What the block decides for one row request.
    typedef struct packed {
        rcl_pkg::t_outcome outcome;
        logic [ROW_W-1:0]  slot;
        logic              evicted;
        logic [ROW_W-1:0]  victim;
        logic [MISS_W-1:0] misses;
    } t_placement;

    // Shadow of the row table, the buffer count and the eviction count.
    bit                  row_held [NUM_ROWS];
    logic [USE_BITS-1:0] row_uses [NUM_ROWS];
    logic [ROW_W-1:0]    row_slot [NUM_ROWS];
    logic [CAP_W-1:0]    held_rows;
    logic [MISS_W-1:0]   evictions;
    logic [CAP_W-1:0]    capacity;

    // Placements predicted for accepted requests, oldest first.
    t_placement placement_q[$];

    // Serves one row request: hit, fresh buffer, or eviction of the least used row.
    function automatic t_placement place_row(input logic [ROW_W-1:0] row);
        t_placement          res;
        logic [CAP_W-1:0]    cap_eff;
        logic [USE_BITS-1:0] least;
        logic [ROW_W-1:0]    victim;
        bit                  have_victim;

        res         = '{outcome: rcl_pkg::OUT_HIT, slot: '0, evicted: 1'b0, victim: '0,
                        misses: '0};
        cap_eff     = (capacity < rcl_pkg::CAP_MIN) ? rcl_pkg::CAP_MIN : capacity;
        least       = '0;
        victim      = '0;
        have_victim = 1'b0;
        if (!row_held[row]) begin
            // The lowest row index wins a tie, since only a strictly smaller count replaces it.
            if (held_rows >= cap_eff) begin
                for (int i = 0; i < NUM_ROWS; i++) begin
                    if (row_held[i] && (!have_victim || row_uses[i] < least)) begin
                        least       = row_uses[i];
                        victim      = ROW_W'(i);
                        have_victim = 1'b1;
                    end
                end
            end
            if (have_victim) begin
                if (evictions != '1) begin
                    evictions++;
                end
                row_slot[row]    = row_slot[victim];
                row_held[victim] = 1'b0;
                row_uses[victim] = '0;
                res.outcome      = rcl_pkg::OUT_EVICT;
                res.evicted      = 1'b1;
                res.victim       = victim;
            end else begin
                row_slot[row] = held_rows[ROW_W-1:0];
                held_rows     = held_rows + 1'b1;
                res.outcome   = rcl_pkg::OUT_FILL;
            end
            row_held[row] = 1'b1;
            row_uses[row] = '0;
        end
        // Use counts stop at their largest value.
        if (row_uses[row] != '1) begin
            row_uses[row]++;
        end
        res.slot   = row_slot[row];
        res.misses = evictions;
        return res;
    endfunction

    // Reports one field that differs from the prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_err_count++;
        end
    endtask

    // Track configuration, book each accepted request and compare each accepted result.
    always @(posedge i_clk) begin
        t_placement want;

        if (!i_rst_n) begin
            foreach (row_held[i]) begin
                row_held[i] = 1'b0;
                row_uses[i] = '0;
                row_slot[i] = '0;
            end
            held_rows = '0;
            evictions = '0;
            capacity  = rcl_pkg::CAP_RESET;
            placement_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (placement_q.size() == 0) begin
                    $error("result with no request pending: outcome %0d, slot %0d",
                           i_rsp.outcome, i_rsp.buffer_slot);
                    o_err_count++;
                end else begin
                    want = placement_q.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(i_rsp.outcome));
                    check_field("buffer_slot", 32'(want.slot), 32'(i_rsp.buffer_slot));
                    check_field("evicted_flag", 32'(want.evicted), 32'(i_rsp.evicted_flag));
                    check_field("evicted_row", 32'(want.victim), 32'(i_rsp.evicted_row));
                    check_field("miss_total", want.misses, i_rsp.miss_total);
                end
            end
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                placement_q.push_back(place_row(i_req.req_row));
            end
        end
        o_pending = placement_q.size();
    end

endmodule

// ===== tb/tb_row_cache_lfu_manager.sv =====
// Testbench top that drives row requests and capacity settings into the LFU manager.
`timescale 1ns / 1ps

module tb_row_cache_lfu_manager;

    localparam int NUM_ROWS      = rcl_pkg::NUM_ROWS;
    localparam int ROW_W         = rcl_pkg::ROW_W;
    localparam int CAP_W         = rcl_pkg::CAP_W;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 144;
    localparam int QUIET_PHASES  = 2;
    localparam int HOT_MAX       = 12;
    localparam int EVICT_BUDGET  = 450;
    localparam int LONG_HOLD_AT  = 500;
    localparam int LONG_HOLD_LEN = 64;
    localparam int SETTLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES   = 1100;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    rcl_req_if req_ch ();
    rcl_rsp_if rsp_ch ();

    int chk_errors;
    int rows_pending;
    int lost_results;
    int results_seen;
    int evictions_seen;
    bit quiet_tail;

    row_cache_lfu_manager i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    rcl_lfu_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_err_count (chk_errors),
        .o_pending   (rows_pending)
    );

    // Clock with an 8 ns period.
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Count delivered results so the receiver and the row mix can react to them.
    always @(posedge clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.outcome == rcl_pkg::OUT_EVICT) begin
                evictions_seen++;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that backs up the block.
    initial begin : result_sink
        int  stall_left;
        bit  long_hold_done;

        stall_left     = 0;
        long_hold_done = 1'b0;
        rsp_ch.ready   = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (stall_left == 0) begin
                if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                    stall_left     = LONG_HOLD_LEN;
                    long_hold_done = 1'b1;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 7);
                end
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one row request, after an occasional idle burst, and waits for its acceptance.
    task automatic offer_row(input logic [ROW_W-1:0] row);
        int gap;

        gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.req_row <= row;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stops offering and waits until every booked request has its result.
    task automatic settle();
        int waited;

        waited = 0;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (rows_pending != 0 && waited < SETTLE_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (rows_pending != 0) begin
            $error("%0d results never arrived", rows_pending);
            lost_results += rows_pending;
        end
    endtask

    // Writes the capacity register while the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus: a directed opening, then phases of hot rows mixed with cold misses.
    initial begin : request_source
        logic [ROW_W-1:0] hot_rows [HOT_MAX];
        logic [ROW_W-1:0] row;
        logic [CAP_W-1:0] cap;
        int               cap_eff;
        int               hot_n;
        int               cold_pct;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.req_row = '0;
        quiet_tail     = 1'b0;
        lost_results   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // At reset capacity: two fresh buffers at the row extremes, then hits.
        offer_row(10'd0);
        offer_row(10'd1023);
        offer_row(10'd0);
        offer_row(10'd1023);
        offer_row(10'd0);

        // A capacity of zero acts as two, so every new row now evicts.
        settle();
        write_capacity(11'd0);
        offer_row(10'd512);
        offer_row(10'd341);
        offer_row(10'd682);
        offer_row(10'd682);
        offer_row(10'd682);
        // Rows 0 and 682 tie on use count here; the lower index must go.
        offer_row(10'd5);

        // A capacity of one also acts as two.
        settle();
        write_capacity(11'd1);
        offer_row(10'd1023);

        // Raising the capacity hands out fresh buffers again before evicting.
        settle();
        write_capacity(11'd4);
        offer_row(10'd100);
        offer_row(10'd200);
        offer_row(10'd300);

        // Largest register value: no eviction while rows remain.
        settle();
        write_capacity(11'd2047);
        offer_row(10'd1);
        offer_row(10'd2);

        // Random phases, each with its own capacity and set of hot rows.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 6)
                0:       cap = 11'd2;
                1:       cap = CAP_W'($urandom_range(3, 16));
                2:       cap = 11'd1024;
                3:       cap = CAP_W'($urandom_range(17, 1024));
                4:       cap = CAP_W'($urandom_range(0, 1));
                default: cap = 11'd2047;
            endcase
            write_capacity(cap);
            quiet_tail = (ph >= PHASES - QUIET_PHASES);

            // Big capacities mostly fill fresh buffers; small ones mostly hit.
            cold_pct = (cap >= 11'd1024) ? 60 : $urandom_range(5, 30);
            cap_eff  = (cap < rcl_pkg::CAP_MIN) ? int'(rcl_pkg::CAP_MIN) : int'(cap);
            hot_n    = (cap_eff - 1 < HOT_MAX) ? cap_eff - 1 : HOT_MAX;
            hot_n    = $urandom_range(1, (hot_n < 1) ? 1 : hot_n);
            foreach (hot_rows[i]) begin
                hot_rows[i] = ROW_W'($urandom_range(0, NUM_ROWS - 1));
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Evictions cost a full row sweep, so cold misses stop past a budget.
                if (evictions_seen < EVICT_BUDGET && $urandom_range(0, 99) < cold_pct) begin
                    row = ROW_W'($urandom_range(0, NUM_ROWS - 1));
                end else begin
                    row = hot_rows[$urandom_range(0, hot_n - 1)];
                end
                offer_row(row);
            end
        end

        // Drain, then leave room for any stray result before the verdict.
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (chk_errors == 0 && lost_results == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
